>>> src/wpwb_pkg.sv
package wpwb_pkg;

	localparam int unsigned MAX_PIXELS_DEF = 4096;
	localparam int unsigned GRAY_BINS      = 256;
	localparam logic [6:0]  PCT_MAX        = 7'd100;
	localparam logic [7:0]  LEVEL_MAX      = 8'd255;
	localparam logic [7:0]  TARGET_RESET   = 8'd255;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// register index (paddr[2])
	localparam logic REG_PERCENT = 1'b0;
	localparam logic REG_TARGET  = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       last_out;
		logic       valid_res;
	} out_t;

	// luma weights sum to 2^14, so the rounded sum fits 22 bits
	function automatic logic [7:0] gray_of(logic [23:0] px);
		logic [21:0] acc;
		acc = 22'd1868 * 22'(px[7:0]) + 22'd9617 * 22'(px[15:8])
			+ 22'd4899 * 22'(px[23:16]) + 22'd8192;
		return acc[21:14];
	endfunction

endpackage

>>> src/wpwb_ram.sv
module wpwb_ram import wpwb_pkg::*; #(
	parameter int unsigned DW    = 24,
	parameter int unsigned DEPTH = MAX_PIXELS_DEF,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/wpwb_scale.sv
module wpwb_scale import wpwb_pkg::*; #(
	parameter int unsigned CW   = 13,
	localparam int unsigned SW  = CW + 8,
	localparam int unsigned NW  = CW + 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] n,
	input  logic [SW-1:0] sum,
	output logic          done,
	output logic [7:0]    res
);

	logic [NW-1:0] rem_q;
	logic [SW-1:0] sum_q;
	logic [7:0]    quo_q;
	logic [2:0]    bit_q;
	logic          busy_q;
	logic          fin_q;
	logic          zero_q;
	logic          sat_q;
	logic          done_q;
	logic [7:0]    res_q;

	logic [NW-1:0] shifted;
	logic [SW:0]   rem2;
	logic          round_up;
	logic [8:0]    quo_r;

	assign shifted  = NW'(sum_q) << bit_q;
	assign rem2     = {rem_q[SW-1:0], 1'b0};
	assign round_up = (rem2 > {1'b0, sum_q}) || ((rem2 == {1'b0, sum_q}) && quo_q[0]);
	assign quo_r    = {1'b0, quo_q} + 9'(round_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= n;
				sum_q  <= sum;
				quo_q  <= '0;
				bit_q  <= 3'd7;
				busy_q <= 1'b1;
				zero_q <= (sum == '0);
				sat_q  <= (n >= {sum, 8'h00});
			end else if (busy_q) begin
				// restoring division, one quotient bit per cycle
				if (rem_q >= shifted) begin
					rem_q        <= rem_q - shifted;
					quo_q[bit_q] <= 1'b1;
				end
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					bit_q <= bit_q - 3'd1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				if (zero_q) begin
					res_q <= '0;
				end else if (sat_q || quo_r[8]) begin
					res_q <= LEVEL_MAX;
				end else begin
					res_q <= quo_r[7:0];
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> src/white_patch_white_balance_core.sv
// load: per pixel, gray on accept, histogram read, histogram write-back
// frame close: single brightest pixel when percent is 0, otherwise a histogram scan
//   up to the threshold bin plus a mean pass over every stored pixel (frame store port)
// fetch: store read, two multiplies, 8-step divide, then the output register
// reset: control, bin valid bits and frame registers clear at once, no clearing pass
module white_patch_white_balance_core import wpwb_pkg::*; #(
	parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  in_t         item,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output out_t        res,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned SW = CW + 8;
	localparam int unsigned NW = CW + 16;
	localparam int unsigned PW = CW + 7;
	localparam logic [CW-1:0] MAXC = CW'(MAX_PIXELS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LD1, ST_LD2, ST_CLOSE,
		ST_SC_RD, ST_SC_ACC, ST_SC_CMP,
		ST_MN_RD, ST_MN_GRAY, ST_MN_ADD,
		ST_FE_RD, ST_FE_M1, ST_FE_M2, ST_FE_ST, ST_FE_WAIT, ST_FE_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [6:0] pct_q;
	logic [7:0] tgt_q;

	// frame state
	logic [CW-1:0]  count_q;
	logic           frame_ready_q;
	logic [255:0]   hval_q;       // histogram bin valid, cleared at frame start
	logic [7:0]     bgray_q;
	logic [23:0]    bpix_q;
	logic [SW-1:0]  ref_sum_q [3];
	logic [CW-1:0]  ref_cnt_q;
	logic [AW-1:0]  ridx_q;

	// load working registers
	logic [23:0]    px_q;
	logic [7:0]     gray_q;
	logic           last_q;
	logic           stored_q;

	// percentile scan and masked mean
	logic [PW-1:0]  need_q;
	logic [CW-1:0]  cum_q;
	logic [7:0]     bin_q;
	logic [7:0]     thr_q;
	logic [AW-1:0]  midx_q;
	logic [23:0]    mpx_s1;
	logic [7:0]     mg_s1;
	logic           hv_s1;

	// fetch path
	logic           last_fe_q;
	logic [15:0]    vt_s1 [3];
	logic [NW-1:0]  n_s2 [3];
	out_t           pend_q;
	out_t           res_q;
	logic           res_valid_q;

	// memories
	logic           st_we;
	logic [AW-1:0]  st_raddr;
	logic [23:0]    st_rdata;
	logic           hi_we;
	logic [7:0]     hi_raddr;
	logic [CW-1:0]  hi_rdata;
	logic [CW-1:0]  hi_wdata;

	// scaling lanes
	logic [2:0]     lane_done;
	logic [7:0]     lane_res [3];

	logic [6:0]     pct_c;
	logic [PW-1:0]  cum100;
	logic           fe_ok;
	logic [CW-1:0]  ridx_nx;
	logic [CW-1:0]  midx_nx;

	// percent above 100 behaves as 100
	assign pct_c   = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;
	// 100*cum as shifts and adds
	assign cum100  = (PW'(cum_q) << 6) + (PW'(cum_q) << 5) + (PW'(cum_q) << 2);
	assign ridx_nx = CW'(ridx_q) + CW'(1);
	assign midx_nx = CW'(midx_q) + CW'(1);
	// a fetch yields a real pixel only with a closed, non-empty frame
	assign fe_ok   = frame_ready_q && (count_q != '0) && (CW'(ridx_q) < count_q);

	// frame store: written on load, read by the mean pass and by fetch
	assign st_we    = (state_q == ST_LD1) && (count_q < MAXC);
	assign st_raddr = (state_q == ST_FE_RD) ? ridx_q : midx_q;

	wpwb_ram #(.DW(24), .DEPTH(MAX_PIXELS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[AW-1:0]),
		.wdata (px_q),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// histogram: read-modify-write across ST_LD1 and ST_LD2, so no overlap on one bin
	assign hi_raddr = (state_q == ST_LD1) ? gray_q : bin_q;
	assign hi_we    = (state_q == ST_LD2) && stored_q;
	assign hi_wdata = (hv_s1 ? hi_rdata : '0) + CW'(1);

	wpwb_ram #(.DW(CW), .DEPTH(GRAY_BINS)) u_hist (
		.clk   (clk),
		.we    (hi_we),
		.waddr (gray_q),
		.wdata (hi_wdata),
		.raddr (hi_raddr),
		.rdata (hi_rdata)
	);

	// valid bit is registered like the histogram read, so both arrive together
	always_ff @(posedge clk) begin
		hv_s1 <= hval_q[hi_raddr];
	end

	// one divider lane per channel, all started together by ST_FE_ST
	for (genvar c = 0; c < 3; c++) begin : g_lane
		wpwb_scale #(.CW(CW)) u_scale (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_FE_ST),
			.n      (n_s2[c]),
			.sum    (ref_sum_q[c]),
			.done   (lane_done[c]),
			.res    (lane_res[c])
		);
	end

	// register port, writes complete in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= '0;
			tgt_q <= TARGET_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_PERCENT: pct_q <= pwdata[6:0];
				REG_TARGET:  tgt_q <= pwdata[7:0];
				default:     pct_q <= pct_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_TARGET) ? {24'h0, tgt_q} : {25'h0, pct_q};
	assign pready = 1'b1;

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			frame_ready_q <= 1'b0;
			hval_q        <= '0;
			bgray_q       <= '0;
			bpix_q        <= '0;
			ref_sum_q     <= '{default: '0};
			ref_cnt_q     <= '0;
			ridx_q        <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			// output register empties on its transfer, unless refilled below
			if (res_valid_q && res_ready && (state_q != ST_FE_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.opcode == OP_LOAD) begin
							px_q    <= {item.red, item.green, item.blue};
							gray_q  <= gray_of({item.red, item.green, item.blue});
							last_q  <= item.last_in;
							// first load after a closed frame starts a new one
							if (frame_ready_q) begin
								hval_q        <= '0;
								count_q       <= '0;
								bgray_q       <= '0;
								bpix_q        <= '0;
								ref_sum_q     <= '{default: '0};
								ref_cnt_q     <= '0;
								ridx_q        <= '0;
								frame_ready_q <= 1'b0;
							end
							state_q <= ST_LD1;
						end else if (fe_ok) begin
							state_q <= ST_FE_RD;
						end else begin
							// no frame: all-zero result
							pend_q <= '0;
							if (frame_ready_q) begin
								ridx_q <= '0;
							end
							state_q <= ST_FE_OUT;
						end
					end
				end
				ST_LD1: begin
					// a full store drops the pixel but still honors last_in
					if (count_q < MAXC) begin
						stored_q <= 1'b1;
						count_q  <= count_q + CW'(1);
						if (count_q == '0 || gray_q > bgray_q) begin
							bgray_q <= gray_q;
							bpix_q  <= px_q;
						end
					end else begin
						stored_q <= 1'b0;
					end
					state_q <= ST_LD2;
				end
				ST_LD2: begin
					if (stored_q) begin
						hval_q[gray_q] <= 1'b1;
					end
					state_q <= last_q ? ST_CLOSE : ST_IDLE;
				end
				ST_CLOSE: begin
					if (pct_c == '0) begin
						// single brightest pixel is the reference
						ref_sum_q[0]  <= SW'(bpix_q[7:0]);
						ref_sum_q[1]  <= SW'(bpix_q[15:8]);
						ref_sum_q[2]  <= SW'(bpix_q[23:16]);
						ref_cnt_q     <= CW'(1);
						ridx_q        <= '0;
						frame_ready_q <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						need_q  <= PW'(PCT_MAX - pct_c) * PW'(count_q);
						cum_q   <= '0;
						bin_q   <= '0;
						state_q <= ST_SC_RD;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_ACC;
				end
				ST_SC_ACC: begin
					cum_q   <= cum_q + (hv_s1 ? hi_rdata : '0);
					state_q <= ST_SC_CMP;
				end
				ST_SC_CMP: begin
					// threshold bin found, or clamp at the top bin
					if (cum100 >= need_q || bin_q == 8'hFF) begin
						thr_q     <= bin_q;
						ref_sum_q <= '{default: '0};
						ref_cnt_q <= '0;
						midx_q    <= '0;
						if (count_q == '0) begin
							ridx_q        <= '0;
							frame_ready_q <= 1'b1;
							state_q       <= ST_IDLE;
						end else begin
							state_q <= ST_MN_RD;
						end
					end else begin
						bin_q   <= bin_q + 8'd1;
						state_q <= ST_SC_RD;
					end
				end
				ST_MN_RD: begin
					state_q <= ST_MN_GRAY;
				end
				ST_MN_GRAY: begin
					mpx_s1  <= st_rdata;
					mg_s1   <= gray_of(st_rdata);
					state_q <= ST_MN_ADD;
				end
				ST_MN_ADD: begin
					// masked mean: accumulate pixels at or above threshold
					if (mg_s1 >= thr_q) begin
						ref_sum_q[0] <= ref_sum_q[0] + SW'(mpx_s1[7:0]);
						ref_sum_q[1] <= ref_sum_q[1] + SW'(mpx_s1[15:8]);
						ref_sum_q[2] <= ref_sum_q[2] + SW'(mpx_s1[23:16]);
						ref_cnt_q    <= ref_cnt_q + CW'(1);
					end
					if (midx_nx == count_q) begin
						ridx_q        <= '0;
						frame_ready_q <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						midx_q  <= midx_q + AW'(1);
						state_q <= ST_MN_RD;
					end
				end
				ST_FE_RD: begin
					// replay wraps to the first pixel after the last
					last_fe_q <= (ridx_nx == count_q);
					ridx_q    <= (ridx_nx >= count_q) ? '0 : ridx_q + AW'(1);
					state_q   <= ST_FE_M1;
				end
				ST_FE_M1: begin
					for (int c = 0; c < 3; c++) begin
						vt_s1[c] <= 16'(st_rdata[8*c +: 8]) * 16'(tgt_q);
					end
					state_q <= ST_FE_M2;
				end
				ST_FE_M2: begin
					for (int c = 0; c < 3; c++) begin
						n_s2[c] <= NW'(vt_s1[c]) * NW'(ref_cnt_q);
					end
					state_q <= ST_FE_ST;
				end
				ST_FE_ST: begin
					state_q <= ST_FE_WAIT;
				end
				ST_FE_WAIT: begin
					if (&lane_done) begin
						pend_q.out_blue  <= lane_res[0];
						pend_q.out_green <= lane_res[1];
						pend_q.out_red   <= lane_res[2];
						pend_q.last_out  <= last_fe_q;
						pend_q.valid_res <= 1'b1;
						state_q          <= ST_FE_OUT;
					end
				end
				ST_FE_OUT: begin
					// hold until the output register is free
					if (!res_valid_q || res_ready) begin
						res_q       <= pend_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

endmodule
